// ===== design/dvdif_pkg.sv =====
// Shared types and constants for the DV DIF frame assembler.
package dvdif_pkg;

  localparam int NUM_BUFFERS_DEF = 4;
  localparam int FRAME_BYTES_DEF = 144000;

  localparam int BUF_W  = 4;
  localparam int ADDR_W = 18;
  localparam int LEN_W  = 11;
  localparam int QCNT_W = 9;

  localparam logic [QCNT_W-1:0] QCNT_MAX     = '1;
  localparam logic [QCNT_W-1:0] HDR_QUADLET  = 9'd3;
  localparam logic [LEN_W-1:0]  LEN_OVERHEAD = 11'd16;
  localparam logic [ADDR_W-1:0] ADDR_SAT     = '1;

  // Item operation codes.
  localparam logic OP_QUADLET = 1'b0;
  localparam logic OP_RETURN  = 1'b1;

  // DIF section types.
  localparam logic [2:0] SECT_HEADER  = 3'd0;
  localparam logic [2:0] SECT_SUBCODE = 3'd1;
  localparam logic [2:0] SECT_VAUX    = 3'd2;
  localparam logic [2:0] SECT_AUDIO   = 3'd3;
  localparam logic [2:0] SECT_VIDEO   = 3'd4;

  typedef struct packed {
    logic              op;
    logic [31:0]       quadlet;
    logic              first;
    logic [LEN_W-1:0]  packet_len;
    logic [BUF_W-1:0]  buffer_index;
  } item_t;

  typedef struct packed {
    logic              write_enable;
    logic [BUF_W-1:0]  write_buffer;
    logic [ADDR_W-1:0] write_address;
    logic [31:0]       write_data;
    logic              frame_done;
    logic [BUF_W-1:0]  done_buffer;
    logic [ADDR_W-1:0] done_bytes;
    logic              underrun_seen;
    logic              overflow_drop;
  } result_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [BUF_W-1:0] push_buf;
  } fifo_req_t;

  typedef struct packed {
    logic [BUF_W-1:0] head_buf;
    logic             empty;
    logic             full;
  } fifo_stat_t;

endpackage

// ===== design/dvdif_free_fifo.sv =====
// Free frame buffer list kept in a small synchronous memory with a prefetched head.
module dvdif_free_fifo import dvdif_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  fifo_req_t  req,
  output fifo_stat_t stat
);

  localparam int PTR_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CNT_W = $clog2(NUM_BUFFERS + 1);

  logic [BUF_W-1:0]       mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] written;
  logic [PTR_W-1:0]       head;
  logic [PTR_W-1:0]       head_next;
  logic [PTR_W-1:0]       tail;
  logic [CNT_W:0]         tail_sum;
  logic [CNT_W-1:0]       count;
  logic                   push;
  logic                   pop;

  // Registered read of the entry at the head, with a bypass for a same-cycle write.
  logic [BUF_W-1:0]       rd_data;
  logic [BUF_W-1:0]       fwd_data;
  logic                   rd_fwd;
  logic                   rd_written;

  assign push = req.push && (count < CNT_W'(NUM_BUFFERS));
  assign pop  = req.pop && (count != '0);

  always_comb begin
    tail_sum = (CNT_W+1)'(head) + (CNT_W+1)'(count);
    if (tail_sum >= (CNT_W+1)'(NUM_BUFFERS)) begin
      tail_sum = tail_sum - (CNT_W+1)'(NUM_BUFFERS);
    end
    tail = tail_sum[PTR_W-1:0];
    head_next = head;
    if (pop) begin
      head_next = (head == PTR_W'(NUM_BUFFERS - 1)) ? '0 : head + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= CNT_W'(NUM_BUFFERS);
      written    <= '0;
      rd_fwd     <= 1'b0;
      rd_written <= 1'b0;
    end else begin
      head <= head_next;
      if (push) begin
        count         <= count + 1'b1;
        written[tail] <= 1'b1;
      end else if (pop) begin
        count <= count - 1'b1;
      end
      rd_fwd     <= push && (tail == head_next);
      rd_written <= written[head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[tail] <= req.push_buf;
    end
    rd_data  <= mem[head_next];
    fwd_data <= req.push_buf;
  end

  // An entry never written reads as its own index.
  assign stat.head_buf = rd_fwd ? fwd_data : (rd_written ? rd_data : BUF_W'(head));
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CNT_W'(NUM_BUFFERS));

endmodule

// ===== design/dvdif_frame_ctrl.sv =====
// Packet tracking, DIF header decode, address generation and frame accounting.
module dvdif_frame_ctrl import dvdif_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  input  fifo_stat_t fifo_stat,
  output fifo_req_t  fifo_req,
  output result_t    res
);

  logic [QCNT_W-1:0] quadlet_count, quadlet_count_next;
  logic [ADDR_W-1:0] packet_base, packet_base_next;
  logic              packet_active, packet_active_next;
  logic              section_known, section_known_next;
  logic              current_valid, current_valid_next;
  logic [BUF_W-1:0]  current_buffer, current_buffer_next;
  logic [ADDR_W-1:0] frame_bytes, frame_bytes_next;
  logic              underrun_flag, underrun_flag_next;

  logic [QCNT_W-1:0] k;
  logic [QCNT_W-1:0] k_off;
  logic [LEN_W-1:0]  byte_off;
  logic [LEN_W-1:0]  pay;
  logic              long_pkt;
  logic [2:0]        sect;
  logic [3:0]        seq;
  logic [7:0]        blk;
  logic [19:0]       blk_div_prod;
  logic [19:0]       sect_off;
  logic [19:0]       base_sum;
  logic [ADDR_W-1:0] hdr_base;
  logic [ADDR_W:0]   addr;
  logic [ADDR_W:0]   byte_sum;

  assign sect = item.quadlet[31:29];
  assign seq  = item.quadlet[23:20];
  assign blk  = item.quadlet[15:8];

  // blk / 15 through a reciprocal; exact for every 8-bit block number.
  assign blk_div_prod = 20'(blk) * 20'd2185;

  always_comb begin
    unique case (sect)
      SECT_HEADER:  sect_off = '0;
      SECT_SUBCODE: sect_off = (20'd1 + 20'(blk)) * 20'd80;
      SECT_VAUX:    sect_off = (20'd3 + 20'(blk)) * 20'd80;
      SECT_AUDIO:   sect_off = (20'd6 + (20'(blk) << 4)) * 20'd80;
      default:      sect_off = (20'd7 + 20'(blk_div_prod[19:15]) + 20'(blk)) * 20'd80;
    endcase
    base_sum = 20'(seq) * 20'd12000 + sect_off;
    hdr_base = (base_sum > 20'(ADDR_SAT)) ? ADDR_SAT : base_sum[ADDR_W-1:0];
  end

  always_comb begin
    quadlet_count_next  = quadlet_count;
    packet_base_next    = packet_base;
    packet_active_next  = packet_active;
    section_known_next  = section_known;
    current_valid_next  = current_valid;
    current_buffer_next = current_buffer;
    frame_bytes_next    = frame_bytes;
    underrun_flag_next  = underrun_flag;
    fifo_req            = '0;
    res                 = '0;

    k        = item.first ? '0 : quadlet_count;
    k_off    = k - HDR_QUADLET;
    byte_off = {k_off, 2'b00};
    long_pkt = item.packet_len > LEN_OVERHEAD;
    pay      = item.packet_len - LEN_OVERHEAD;
    addr     = '0;
    byte_sum = '0;

    if (item.op == OP_QUADLET) begin
      if (item.first) begin
        packet_active_next = long_pkt;
      end
      quadlet_count_next = (k < QCNT_MAX) ? k + 1'b1 : QCNT_MAX;

      if (packet_active_next && long_pkt && (k >= HDR_QUADLET)) begin
        if (k == HDR_QUADLET) begin
          if ((sect == SECT_HEADER) && (seq == '0)) begin
            if (current_valid) begin
              res.frame_done  = 1'b1;
              res.done_buffer = current_buffer;
              res.done_bytes  = frame_bytes;
            end
            current_valid_next = 1'b0;
            if (!fifo_stat.empty) begin
              current_buffer_next = fifo_stat.head_buf;
              current_valid_next  = 1'b1;
              frame_bytes_next    = '0;
              fifo_req.pop        = accept;
            end else begin
              underrun_flag_next = 1'b1;
            end
          end
          section_known_next = (sect <= SECT_VIDEO);
          packet_base_next   = section_known_next ? hdr_base : '0;
          if (current_valid_next) begin
            byte_sum = (ADDR_W+1)'(frame_bytes_next) + (ADDR_W+1)'(pay);
            frame_bytes_next = byte_sum[ADDR_W] ? ADDR_SAT : byte_sum[ADDR_W-1:0];
          end
        end
        if (current_valid_next && section_known_next && (byte_off < pay)) begin
          addr = (ADDR_W+1)'(packet_base_next) + (ADDR_W+1)'(byte_off);
          if (addr <= (ADDR_W+1)'(FRAME_BYTES - 4)) begin
            res.write_enable  = 1'b1;
            res.write_buffer  = current_buffer_next;
            res.write_address = addr[ADDR_W-1:0];
            res.write_data    = item.quadlet;
          end else begin
            res.overflow_drop = 1'b1;
          end
        end
      end
    end else if (!fifo_stat.full) begin
      fifo_req.push     = accept;
      fifo_req.push_buf = item.buffer_index;
    end

    res.underrun_seen = underrun_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quadlet_count  <= '0;
      packet_base    <= '0;
      packet_active  <= 1'b0;
      section_known  <= 1'b0;
      current_valid  <= 1'b0;
      current_buffer <= '0;
      frame_bytes    <= '0;
      underrun_flag  <= 1'b0;
    end else if (accept) begin
      quadlet_count  <= quadlet_count_next;
      packet_base    <= packet_base_next;
      packet_active  <= packet_active_next;
      section_known  <= section_known_next;
      current_valid  <= current_valid_next;
      current_buffer <= current_buffer_next;
      frame_bytes    <= frame_bytes_next;
      underrun_flag  <= underrun_flag_next;
    end
  end

endmodule

// ===== design/dv_dif_packet_frame_assembler_top.sv =====
// Top level of the DV DIF frame assembler: packet control, free buffer list, output register.
//
// The block takes one beat per clock, either a packet quadlet or a buffer returned by the
// host, and gives exactly one result beat for each, registered through a
// single output register; the sustained rate is one beat per clock while the result side
// takes beats. The free buffer list lives in a small synchronous memory whose registered
// read is aimed at the next head entry, so the next free buffer is always
// ready when a frame-start header arrives; a buffer returned in the same cycle as that
// read is bypassed straight into the head register. Entries of the free list carry a
// written bit each, and an entry never written reads as its own index, so no clearing
// pass follows reset. A packet is used only when it is longer than 16 bytes; its fourth
// quadlet carries the DIF header, and a header of section 0, sequence 0 closes the
// current frame (frame_done with its saturating byte count) and takes the next free
// buffer, setting the sticky underrun flag when none is left. Payload quadlets get a
// byte address from the section rules; writes that would pass the frame size are
// dropped and flagged with overflow_drop.
module dv_dif_packet_frame_assembler_top import dvdif_pkg::*; #(
  parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic       accept;
  result_t    res_next;
  fifo_req_t  fifo_req;
  fifo_stat_t fifo_stat;

  // The output register frees up whenever its beat is taken, so a new beat can enter
  // in the same cycle.
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  dvdif_frame_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .fifo_stat (fifo_stat),
    .fifo_req  (fifo_req),
    .res       (res_next)
  );

  dvdif_free_fifo #(
    .NUM_BUFFERS(NUM_BUFFERS)
  ) u_free (
    .clk  (clk),
    .rst  (rst),
    .req  (fifo_req),
    .stat (fifo_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  // Frame addresses are section bases (multiples of 80) plus whole quadlets.
  a_write_aligned: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_enable |-> result.write_address[1:0] == 2'b00)
    else $error("write address not quadlet aligned");

  // A stored quadlet always fits inside the frame.
  a_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.write_enable |->
      result.write_address <= ADDR_W'(FRAME_BYTES - 4))
    else $error("write address past frame end");

  // A quadlet is either stored or dropped for overflow, never both.
  a_write_or_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.write_enable && result.overflow_drop))
    else $error("write and overflow drop together");

  // A buffer is only taken from the free list while it holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fifo_req.pop |-> !fifo_stat.empty && !fifo_req.push)
    else $error("free list popped while empty");
`endif

endmodule
